// ===== rtl/cwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherent window averager package
// Shared widths, register indexes, queue item formats and back-end states.
// ----------------------------------------------------------------------------
package cwa_pkg;

   // Field widths fixed by the interface.
   localparam int CfgW      = 11;
   localparam int SampleW   = 16;
   localparam int AccW      = 26;
   localparam int DivCntW   = 5;
   localparam int CsrIndexW = 1;

   // Saturation limits of an averaged sample, as magnitudes.
   localparam logic [AccW-1:0] PosLimit = AccW'(32767);
   localparam logic [AccW-1:0] NegLimit = AccW'(32768);

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_AVERAGE_COUNT = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } cwa_csr_type;

   // One classified sample, handed from the front end to the back end.
   typedef struct packed {
      logic signed [SampleW-1:0] sample_re;
      logic signed [SampleW-1:0] sample_im;
      logic                      last_sample;
      logic                      last_window;
      logic [CfgW-1:0]           count;
   } cwa_item_type;

   // One averaged result.
   typedef struct packed {
      logic signed [SampleW-1:0] avg_re;
      logic signed [SampleW-1:0] avg_im;
      logic                      window_end;
   } cwa_result_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_READ,
      BACK_DIV
   } cwa_back_state_type;

endpackage

// ===== rtl/cwa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module cwa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written on each push transfer.
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/cwa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherent window averager front end
// Accepts samples, tracks window position and window count, and tags each
// sample with its accumulator index and end-of-window flags.
// ----------------------------------------------------------------------------
module cwa_front #(
   parameter int MAX_WINDOW  = 1024,
   parameter int MAX_AVERAGE = 1024,
   parameter int PosW        = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cwa_pkg::CfgW-1:0]              average_count,
   input  logic [cwa_pkg::CfgW-1:0]              window_length,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [cwa_pkg::SampleW-1:0]    sample_re,
   input  logic signed [cwa_pkg::SampleW-1:0]    sample_im,
   input  logic                                  queue_full,
   input  logic                                  clearing,
   output logic                                  queue_push,
   output cwa_pkg::cwa_item_type                 queue_item,
   output logic [PosW-1:0]                       queue_pos
);
   import cwa_pkg::*;

   localparam int LenW  = $clog2(MAX_WINDOW + 1);
   localparam int DoneW = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;

   logic [PosW-1:0]  position_ff, position_in;
   logic [DoneW-1:0] windows_done_ff, windows_done_in;
   logic [LenW-1:0]  len;
   logic [LenW-1:0]  pos_ext;
   logic [CfgW-1:0]  cnt;
   logic             last_sample;
   logic             last_window;

   // No transfers while the queue is full or the accumulators are clearing.
   assign full       = queue_full || clearing;
   assign queue_push = push && !full;

   // Effective window length and average count, zero as one, clamped to max.
   always_comb begin
      if (window_length == '0) begin
         len = LenW'(1);
      end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
         len = LenW'(MAX_WINDOW);
      end else begin
         len = LenW'(window_length);
      end
      if (average_count == '0) begin
         cnt = CfgW'(1);
      end else if (32'(average_count) > 32'(MAX_AVERAGE)) begin
         cnt = CfgW'(MAX_AVERAGE);
      end else begin
         cnt = average_count;
      end
   end

   // Position is pulled back into a window that was shortened.
   always_comb begin
      pos_ext = LenW'(position_ff);
      if (pos_ext >= len) begin
         pos_ext = len - LenW'(1);
      end
      last_sample = ({1'b0, pos_ext} + (LenW + 1)'(1)) >= {1'b0, len};
      last_window = (32'(windows_done_ff) + 32'd1) >= 32'(cnt);
   end

   // Classified item.
   always_comb begin
      queue_item.sample_re   = sample_re;
      queue_item.sample_im   = sample_im;
      queue_item.last_sample = last_sample;
      queue_item.last_window = last_window;
      queue_item.count       = cnt;
      queue_pos              = PosW'(pos_ext);
   end

   // Counter update on each input transfer.
   always_comb begin
      position_in     = position_ff;
      windows_done_in = windows_done_ff;
      if (queue_push) begin
         if (last_sample) begin
            position_in     = '0;
            windows_done_in = last_window ? '0 : windows_done_ff + DoneW'(1);
         end else begin
            position_in = PosW'(pos_ext + LenW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         windows_done_ff <= '0;
      end else begin
         position_ff     <= position_in;
         windows_done_ff <= windows_done_in;
      end
   end

endmodule

// ===== rtl/cwa_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherent window averager divider
// Radix-2 restoring divider, one quotient bit per cycle, with truncation
// toward zero and saturation of the quotient to 16-bit signed.
// ----------------------------------------------------------------------------
module cwa_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cwa_pkg::AccW-1:0]    dividend,
   input  logic [cwa_pkg::CfgW-1:0]           divisor,
   output logic                               busy,
   output logic signed [cwa_pkg::SampleW-1:0] quotient
);
   import cwa_pkg::*;

   logic                busy_ff, busy_in;
   logic [DivCntW-1:0]  step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [AccW-1:0]     quo_ff, quo_in;
   logic [CfgW-1:0]     rem_ff, rem_in;
   logic [CfgW-1:0]     div_ff, div_in;
   logic [CfgW:0]       shifted;
   logic                take;

   assign busy = busy_ff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted   = {rem_ff, quo_ff[AccW-1]};
      take      = (shifted >= {1'b0, div_ff});
      busy_in   = busy_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[AccW-1];
         quo_in  = dividend[AccW-1] ? AccW'(-dividend) : AccW'(dividend);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = take ? CfgW'(shifted - {1'b0, div_ff}) : CfgW'(shifted);
         quo_in  = {quo_ff[AccW-2:0], take};
         step_in = step_ff + DivCntW'(1);
         if (step_ff == DivCntW'(AccW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // Sign restore and saturation of the magnitude quotient.
   always_comb begin
      if (!neg_ff) begin
         quotient = (quo_ff > PosLimit) ? 16'sh7fff : signed'(quo_ff[SampleW-1:0]);
      end else if (quo_ff >= NegLimit) begin
         quotient = 16'sh8000;
      end else begin
         quotient = signed'(SampleW'(~quo_ff[SampleW-1:0] + SampleW'(1)));
      end
   end

endmodule

// ===== rtl/cwa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherent window averager back end
// Owns the accumulator memory: clears it after reset, does the
// read-modify-write per sample and divides samples of the averaged window.
// ----------------------------------------------------------------------------
module cwa_back #(
   parameter int MAX_WINDOW = 1024,
   parameter int PosW       = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  cwa_pkg::cwa_item_type   queue_item,
   input  logic [PosW-1:0]         queue_pos,
   output logic                    queue_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output cwa_pkg::cwa_result_type out_result,
   output logic                    clearing
);
   import cwa_pkg::*;

   localparam int MemW = 2 * AccW;

   cwa_back_state_type state_ff, state_in;
   logic [PosW-1:0]    clr_ff, clr_in;
   cwa_item_type       item_ff;
   logic [PosW-1:0]    pos_ff;

   logic [MemW-1:0]    mem [MAX_WINDOW];
   logic [MemW-1:0]    rd_data_ff;
   logic               wr_en;
   logic [PosW-1:0]    wr_addr;
   logic [MemW-1:0]    wr_data;

   logic signed [AccW-1:0] sum_re, sum_im;
   logic               div_start;
   logic               busy_re, busy_im;
   logic signed [SampleW-1:0] q_re, q_im;

   assign clearing = (state_ff == BACK_CLEAR);

   // Sums wrap within the accumulator width.
   always_comb begin
      sum_re = signed'(rd_data_ff[MemW-1:AccW])
               + {{(AccW - SampleW){item_ff.sample_re[SampleW-1]}}, item_ff.sample_re};
      sum_im = signed'(rd_data_ff[AccW-1:0])
               + {{(AccW - SampleW){item_ff.sample_im[SampleW-1]}}, item_ff.sample_im};
   end

   // Sequencer: clearing pass, then fetch, update and optional divide.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      queue_pop  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = '0;
      div_start  = 1'b0;
      out_push   = 1'b0;
      out_result.avg_re     = q_re;
      out_result.avg_im     = q_im;
      out_result.window_end = item_ff.last_sample;
      case (state_ff)
         BACK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + PosW'(1);
            if (clr_ff == PosW'(MAX_WINDOW - 1)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               state_in  = BACK_READ;
            end
         end
         BACK_READ: begin
            wr_en = 1'b1;
            if (item_ff.last_window) begin
               div_start = 1'b1;
               state_in  = BACK_DIV;
            end else begin
               wr_data  = {sum_re, sum_im};
               state_in = BACK_IDLE;
            end
         end
         BACK_DIV: begin
            if (!busy_re && !busy_im && !out_full) begin
               out_push = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Item capture on each transfer out of the queue.
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         item_ff <= queue_item;
         pos_ff  <= queue_pos;
      end
   end

   // Accumulator memory with registered read at the queue head index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[queue_pos];
   end

   // Dividers for both components run side by side.
   cwa_divider u_div_re (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_re),
      .divisor  (item_ff.count),
      .busy     (busy_re),
      .quotient (q_re)
   );

   cwa_divider u_div_im (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_im),
      .divisor  (item_ff.count),
      .busy     (busy_im),
      .quotient (q_im)
   );

endmodule

// ===== rtl/coherent_window_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherent window averager
// Sums complex samples per window position over a configured number of
// windows and emits the truncated average of the last window.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on push/full; a transfer happens when push is high and full
//   is low. Averaged samples leave on empty/pop; the oldest result sits on the
//   rsp_ ports while empty is low and is taken when pop is high. Registers are
//   written on csr_valid (csr_ready is always high); the user must write them
//   only while the block is idle, which the block does not enforce. Only
//   samples of every average_count-th window give results; window_end marks
//   the last sample of such a window. Timing: the front end takes a sample
//   per cycle while full is low into a four-entry queue. The back end reads,
//   then writes the accumulator memory per summed sample, and per averaged
//   sample does the read, 26 divide steps of the bit-serial divider and the
//   output push; the divider sets the averaged rate. Reset: counters clear
//   and a clearing pass writes zero to every one of the MAX_WINDOW
//   accumulator entries, one per cycle; full stays high meanwhile. A stalled
//   receiver fills the two-entry result queue, then the back end waits, the
//   input queue fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module coherent_window_averager #(
   parameter int MAX_WINDOW  = 1024,
   parameter int MAX_AVERAGE = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [cwa_pkg::SampleW-1:0]    req_sample_re,
   input  logic signed [cwa_pkg::SampleW-1:0]    req_sample_im,
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [cwa_pkg::SampleW-1:0]    rsp_avg_re,
   output logic signed [cwa_pkg::SampleW-1:0]    rsp_avg_im,
   output logic                                  rsp_window_end,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cwa_pkg::CsrIndexW-1:0]         csr_index,
   input  logic [cwa_pkg::CfgW-1:0]              csr_data
);
   import cwa_pkg::*;

   localparam int PosW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ItemW  = PosW + $bits(cwa_item_type);
   localparam int ResW   = $bits(cwa_result_type);

   logic [CfgW-1:0] average_count_ff, average_count_in;
   logic [CfgW-1:0] window_length_ff, window_length_in;

   logic            in_push, in_full, in_empty, in_pop;
   cwa_item_type    front_item;
   logic [PosW-1:0] front_pos;
   logic [ItemW-1:0] in_head;
   cwa_item_type    back_item;
   logic [PosW-1:0] back_pos;
   logic            clearing;

   logic            out_push, out_full;
   cwa_result_type  back_result;
   logic [ResW-1:0] out_head;
   cwa_result_type  rsp_result;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      average_count_in = average_count_ff;
      window_length_in = window_length_ff;
      if (csr_valid) begin
         case (cwa_csr_type'(csr_index))
            CSR_AVERAGE_COUNT: average_count_in = csr_data;
            CSR_WINDOW_LENGTH: window_length_in = csr_data;
            default: begin
               average_count_in = average_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         average_count_ff <= CfgW'(1);
         window_length_ff <= CfgW'(1024);
      end else begin
         average_count_ff <= average_count_in;
         window_length_ff <= window_length_in;
      end
   end

   // Front end: accept and classify.
   cwa_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_AVERAGE (MAX_AVERAGE),
      .PosW        (PosW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .average_count (average_count_ff),
      .window_length (window_length_ff),
      .push          (push),
      .full          (full),
      .sample_re     (req_sample_re),
      .sample_im     (req_sample_im),
      .queue_full    (in_full),
      .clearing      (clearing),
      .queue_push    (in_push),
      .queue_item    (front_item),
      .queue_pos     (front_pos)
   );

   // Queue between the front and back ends.
   cwa_fifo #(
      .WIDTH (ItemW),
      .DEPTH (4)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_push),
      .push_data ({front_pos, front_item}),
      .pop       (in_pop),
      .head      (in_head),
      .full      (in_full),
      .empty     (in_empty)
   );

   assign back_pos  = in_head[ItemW-1 -: PosW];
   assign back_item = cwa_item_type'(in_head[$bits(cwa_item_type)-1:0]);

   // Back end: accumulate and average.
   cwa_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .PosW       (PosW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (in_empty),
      .queue_item  (back_item),
      .queue_pos   (back_pos),
      .queue_pop   (in_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_result  (back_result),
      .clearing    (clearing)
   );

   // Result queue toward the receiver.
   cwa_fifo #(
      .WIDTH (ResW),
      .DEPTH (2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .pop       (pop),
      .head      (out_head),
      .full      (out_full),
      .empty     (empty)
   );

   assign rsp_result     = cwa_result_type'(out_head);
   assign rsp_avg_re     = rsp_result.avg_re;
   assign rsp_avg_im     = rsp_result.avg_im;
   assign rsp_window_end = rsp_result.window_end;

endmodule
